// File: hw/rtl/tmpr_pkg.sv
// ----------------------------------------------------------------------------
// tmpr_pkg
// Shared types, constants and helpers for the text mode pixel renderer.
// ----------------------------------------------------------------------------
package tmpr_pkg;

    localparam int CELL_DEPTH_DEF     = 8192;
    localparam int GLYPH_COUNT_DEF    = 512;
    localparam int GLYPH_ROWS_MAX_DEF = 32;
    localparam int FONT_DEPTH         = 65536;
    localparam int QUEUE_DEPTH        = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [7:0] COLUMNS_RST      = 8'd80;
    localparam logic [7:0] LINES_RST        = 8'd25;
    localparam logic [5:0] GLYPH_WIDTH_RST  = 6'd8;
    localparam logic [5:0] GLYPH_HEIGHT_RST = 6'd16;

    localparam logic [5:0] GLYPH_DIM_MAX = 6'd32;

    localparam logic [7:0] LEVEL_OFF  = 8'd0;
    localparam logic [7:0] LEVEL_DIM  = 8'd192;
    localparam logic [7:0] LEVEL_LOW  = 8'd64;
    localparam logic [7:0] LEVEL_FULL = 8'd255;

    typedef enum logic [1:0] {
        OP_WRITE_CELL = 2'd0,
        OP_WRITE_FONT = 2'd1,
        OP_RENDER     = 2'd2,
        OP_IGNORE     = 2'd3
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COLUMNS        = 3'd0,
        REG_LINES          = 3'd1,
        REG_GLYPH_WIDTH    = 3'd2,
        REG_GLYPH_HEIGHT   = 3'd3,
        REG_HIGH_FONT_MASK = 3'd4,
        REG_CURSOR_COLUMN  = 3'd5,
        REG_CURSOR_ROW     = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]  columns;
        logic [7:0]  lines;
        logic [5:0]  glyph_width;
        logic [5:0]  glyph_height;
        logic [15:0] high_font_mask;
        logic [7:0]  cursor_column;
        logic [7:0]  cursor_row;
    } cfg_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] address;
        logic [15:0] value;
        logic [4:0]  pix_col;
        logic [7:0]  cell_col;
        logic [4:0]  pix_row;
        logic [7:0]  cell_row;
        logic        cursor;
        logic        frame_end;
    } item_t;

    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    function automatic logic [5:0] glyph_dim(input logic [5:0] v);
        logic [5:0] r;
        if (v == 6'd0)
        begin
            r = 6'd1;
        end
        else if (v > GLYPH_DIM_MAX)
        begin
            r = GLYPH_DIM_MAX;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // bytes per glyph row: ceil(width / 8), 1..4
    function automatic logic [2:0] row_bytes(input logic [5:0] gw);
        logic [6:0] s;
        s = {1'b0, gw} + 7'd7;
        return s[5:3];
    endfunction

    // bit "on" picks the lit level, bit "bright" the bright half of the palette
    function automatic logic [7:0] pal_level(input logic bright, input logic on);
        logic [7:0] r;
        case ({bright, on})
            2'b00:   r = LEVEL_OFF;
            2'b01:   r = LEVEL_DIM;
            2'b10:   r = LEVEL_LOW;
            default: r = LEVEL_FULL;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/tmpr_ram.sv
// ----------------------------------------------------------------------------
// tmpr_ram
// Generic single write port RAM with one registered, read-first read port.
// ----------------------------------------------------------------------------
module tmpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/tmpr_front.sv
// ----------------------------------------------------------------------------
// tmpr_front
// Input side: accepts items, tracks the raster position and tags each
// render item with its pixel coordinates, cursor hit and frame end.
// ----------------------------------------------------------------------------
module tmpr_front (
    input  logic            clk,
    input  logic            rst_n,
    input  tmpr_pkg::cfg_t  cfg,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [1:0]      operation,
    input  logic [15:0]     address,
    input  logic [15:0]     value,
    input  logic            q_full,
    output logic            q_push,
    output tmpr_pkg::item_t q_item
);
    import tmpr_pkg::*;

    logic [4:0] pix_col_reg, pix_col_next;
    logic [7:0] cell_col_reg, cell_col_next;
    logic [4:0] pix_row_reg, pix_row_next;
    logic [7:0] cell_row_reg, cell_row_next;

    logic [7:0] cols_eff, rows_eff;
    logic [5:0] gw_eff, gh_eff;
    logic       pc_wrap, cc_wrap, pr_wrap, cr_wrap;
    logic       last_col, last_row, cursor_hit;
    op_t        op;

    assign op       = op_t'(operation);
    assign cols_eff = at_least_one(cfg.columns);
    assign rows_eff = at_least_one(cfg.lines);
    assign gw_eff   = glyph_dim(cfg.glyph_width);
    assign gh_eff   = glyph_dim(cfg.glyph_height);

    assign pc_wrap  = ({1'b0, pix_col_reg} + 6'd1) >= gw_eff;
    assign cc_wrap  = ({1'b0, cell_col_reg} + 9'd1) >= {1'b0, cols_eff};
    assign pr_wrap  = ({1'b0, pix_row_reg} + 6'd1) >= gh_eff;
    assign cr_wrap  = ({1'b0, cell_row_reg} + 9'd1) >= {1'b0, rows_eff};
    assign last_col = pc_wrap && cc_wrap;
    assign last_row = last_col && pr_wrap && cr_wrap;

    assign cursor_hit = (cell_row_reg == cfg.cursor_row)
                     && (cell_col_reg == cfg.cursor_column)
                     && (({2'b0, pix_row_reg} + 7'd2) >= {1'b0, gh_eff});

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.op        = op;
        q_item.address   = address;
        q_item.value     = value;
        q_item.pix_col   = pix_col_reg;
        q_item.cell_col  = cell_col_reg;
        q_item.pix_row   = pix_row_reg;
        q_item.cell_row  = cell_row_reg;
        q_item.cursor    = cursor_hit;
        q_item.frame_end = (op == OP_RENDER) && last_row;
    end

    always_comb
    begin
        pix_col_next  = pix_col_reg;
        cell_col_next = cell_col_reg;
        pix_row_next  = pix_row_reg;
        cell_row_next = cell_row_reg;
        if (q_push && (op == OP_RENDER))
        begin
            if (pc_wrap)
            begin
                pix_col_next  = 5'd0;
                cell_col_next = cc_wrap ? 8'd0 : cell_col_reg + 8'd1;
            end
            else
            begin
                pix_col_next = pix_col_reg + 5'd1;
            end
            if (last_col)
            begin
                if (pr_wrap)
                begin
                    pix_row_next  = 5'd0;
                    cell_row_next = cr_wrap ? 8'd0 : cell_row_reg + 8'd1;
                end
                else
                begin
                    pix_row_next = pix_row_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_col_reg  <= '0;
            cell_col_reg <= '0;
            pix_row_reg  <= '0;
            cell_row_reg <= '0;
        end
        else
        begin
            pix_col_reg  <= pix_col_next;
            cell_col_reg <= cell_col_next;
            pix_row_reg  <= pix_row_next;
            cell_row_reg <= cell_row_next;
        end
    end

endmodule

// File: hw/rtl/tmpr_queue.sv
// ----------------------------------------------------------------------------
// tmpr_queue
// Short item FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module tmpr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tmpr_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output tmpr_pkg::item_t head_item
);
    import tmpr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    item_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head_item = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/tmpr_back.sv
// ----------------------------------------------------------------------------
// tmpr_back
// Execution side: cell index, cell store access, glyph decode, font store
// access and palette lookup, one item per stage.
// ----------------------------------------------------------------------------
module tmpr_back #(
    parameter int CELL_DEPTH     = tmpr_pkg::CELL_DEPTH_DEF,
    parameter int GLYPH_COUNT    = tmpr_pkg::GLYPH_COUNT_DEF,
    parameter int GLYPH_ROWS_MAX = tmpr_pkg::GLYPH_ROWS_MAX_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  tmpr_pkg::cfg_t  cfg,
    input  logic            q_not_empty,
    input  tmpr_pkg::item_t q_item,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [7:0]      red,
    output logic [7:0]      green,
    output logic [7:0]      blue,
    output logic            pixel_valid,
    output logic            frame_end
);
    import tmpr_pkg::*;

    localparam int CELL_AW  = $clog2(CELL_DEPTH);
    localparam int GLYPH_AW = $clog2(GLYPH_COUNT);
    localparam int FONT_AW  = $clog2(FONT_DEPTH);
    localparam int GB_W     = GLYPH_AW + 3;
    localparam logic [9:0] GLYPH_COUNT_C = 10'(GLYPH_COUNT);

    logic advance;

    // stage 1: cell index
    logic               s1_valid_reg;
    item_t              s1_item_reg;
    logic [CELL_AW-1:0] s1_idx_reg, s1_idx_next;
    logic [15:0]        row_base;
    logic [16:0]        idx_sum;

    // stage 2: cell read
    logic        s2_valid_reg;
    item_t       s2_item_reg;
    logic [15:0] cell_rdata;

    // stage 3: glyph decode
    logic                s3_valid_reg;
    item_t               s3_item_reg;
    logic [GLYPH_AW-1:0] s3_sym_reg, s3_sym_next;
    logic [3:0]          s3_fg_reg, s3_fg_next;
    logic [3:0]          s3_bg_reg, s3_bg_next;
    logic [9:0]          sym_raw;
    logic [15:0]         lower, word_sq;

    // stage 4: font read
    logic               s4_valid_reg;
    item_t              s4_item_reg;
    logic [3:0]         s4_fg_reg, s4_bg_reg;
    logic [2:0]         rbytes;
    logic [GB_W-1:0]    glyph_base;
    logic [7:0]         row_off;
    logic [FONT_AW-1:0] font_addr;
    logic [7:0]         font_rdata;

    // output
    logic       out_valid_reg;
    logic [7:0] red_reg, red_next;
    logic [7:0] green_reg, green_next;
    logic [7:0] blue_reg, blue_next;
    logic       pixel_valid_reg, pixel_valid_next;
    logic       frame_end_reg, frame_end_next;
    logic       lit;
    logic [3:0] color;

    assign advance = !out_valid_reg || !out_stall;
    assign q_pop   = advance && q_not_empty;

    assign row_base    = q_item.cell_row * at_least_one(cfg.columns);
    assign idx_sum     = {1'b0, row_base} + {9'd0, q_item.cell_col};
    assign s1_idx_next = idx_sum[CELL_AW-1:0];

    tmpr_ram #(
        .WIDTH (16),
        .DEPTH (CELL_DEPTH)
    ) u_cell_ram (
        .clk     (clk),
        .wr_en   (advance && s1_valid_reg && (s1_item_reg.op == OP_WRITE_CELL)),
        .wr_addr (s1_item_reg.address[CELL_AW-1:0]),
        .wr_data (s1_item_reg.value),
        .rd_en   (advance),
        .rd_addr (s1_idx_reg),
        .rd_data (cell_rdata)
    );

    always_comb
    begin
        sym_raw = {1'b0, |(cell_rdata & cfg.high_font_mask), cell_rdata[7:0]};
        if (sym_raw >= GLYPH_COUNT_C)
        begin
            sym_raw = sym_raw - GLYPH_COUNT_C;
        end
        s3_sym_next = sym_raw[GLYPH_AW-1:0];
        // squeeze the high font bit out of the attribute
        lower = cfg.high_font_mask - 16'd1;
        if (lower != 16'd0)
        begin
            word_sq = (cell_rdata & lower) | ((cell_rdata >> 1) & ~lower);
        end
        else
        begin
            word_sq = cell_rdata;
        end
        s3_fg_next = word_sq[11:8];
        s3_bg_next = word_sq[15:12];
    end

    assign rbytes     = row_bytes(glyph_dim(cfg.glyph_width));
    assign glyph_base = GB_W'(s3_sym_reg) * GB_W'(rbytes);
    assign row_off    = 8'(rbytes) * 8'(s3_item_reg.pix_row);
    assign font_addr  = FONT_AW'(glyph_base) * FONT_AW'(GLYPH_ROWS_MAX)
                      + FONT_AW'(row_off) + FONT_AW'(s3_item_reg.pix_col[4:3]);

    tmpr_ram #(
        .WIDTH (8),
        .DEPTH (FONT_DEPTH)
    ) u_font_ram (
        .clk     (clk),
        .wr_en   (advance && s3_valid_reg && (s3_item_reg.op == OP_WRITE_FONT)),
        .wr_addr (s3_item_reg.address[FONT_AW-1:0]),
        .wr_data (s3_item_reg.value[7:0]),
        .rd_en   (advance),
        .rd_addr (font_addr),
        .rd_data (font_rdata)
    );

    always_comb
    begin
        lit   = font_rdata[3'd7 - s4_item_reg.pix_col[2:0]] || s4_item_reg.cursor;
        color = lit ? s4_fg_reg : s4_bg_reg;
        if (s4_item_reg.op == OP_RENDER)
        begin
            red_next         = pal_level(color[3], color[2]);
            green_next       = pal_level(color[3], color[1]);
            blue_next        = pal_level(color[3], color[0]);
            pixel_valid_next = 1'b1;
            frame_end_next   = s4_item_reg.frame_end;
        end
        else
        begin
            red_next         = 8'd0;
            green_next       = 8'd0;
            blue_next        = 8'd0;
            pixel_valid_next = 1'b0;
            frame_end_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= q_not_empty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_item_reg     <= q_item;
            s1_idx_reg      <= s1_idx_next;
            s2_item_reg     <= s1_item_reg;
            s3_item_reg     <= s2_item_reg;
            s3_sym_reg      <= s3_sym_next;
            s3_fg_reg       <= s3_fg_next;
            s3_bg_reg       <= s3_bg_next;
            s4_item_reg     <= s3_item_reg;
            s4_fg_reg       <= s3_fg_reg;
            s4_bg_reg       <= s3_bg_reg;
            red_reg         <= red_next;
            green_reg       <= green_next;
            blue_reg        <= blue_next;
            pixel_valid_reg <= pixel_valid_next;
            frame_end_reg   <= frame_end_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign pixel_valid = pixel_valid_reg;
    assign frame_end   = frame_end_reg;

endmodule

// File: hw/rtl/text_mode_pixel_renderer_core.sv
// ----------------------------------------------------------------------------
// text_mode_pixel_renderer_core
// Text mode character generator: cell and font stores, raster pixel output.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_stall is low and returns one result per
// item, in order. Each render item needs one cell store read followed by
// one font store read, so those two RAM ports, one per pipeline stage, set
// the rate of one pixel per clock while the output is not stalled.
// A four-entry queue separates the input side from the pipeline; the input
// stalls only when that queue is full. The cell store depth and glyph count
// are taken as powers of two for address wrapping; store contents are
// undefined until written.
module text_mode_pixel_renderer_core #(
    parameter int CELL_DEPTH     = tmpr_pkg::CELL_DEPTH_DEF,
    parameter int GLYPH_COUNT    = tmpr_pkg::GLYPH_COUNT_DEF,
    parameter int GLYPH_ROWS_MAX = tmpr_pkg::GLYPH_ROWS_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tmpr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tmpr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      operation,
    input  logic [15:0]                     address,
    input  logic [15:0]                     value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      red,
    output logic [7:0]                      green,
    output logic [7:0]                      blue,
    output logic                            pixel_valid,
    output logic                            frame_end
);
    import tmpr_pkg::*;

    cfg_t  cfg_reg;
    item_t push_item, head_item;
    logic  q_push, q_full, q_pop, q_not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.columns        <= COLUMNS_RST;
            cfg_reg.lines          <= LINES_RST;
            cfg_reg.glyph_width    <= GLYPH_WIDTH_RST;
            cfg_reg.glyph_height   <= GLYPH_HEIGHT_RST;
            cfg_reg.high_font_mask <= '0;
            cfg_reg.cursor_column  <= '0;
            cfg_reg.cursor_row     <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_COLUMNS:        cfg_reg.columns        <= cfg_data[7:0];
                REG_LINES:          cfg_reg.lines          <= cfg_data[7:0];
                REG_GLYPH_WIDTH:    cfg_reg.glyph_width    <= cfg_data[5:0];
                REG_GLYPH_HEIGHT:   cfg_reg.glyph_height   <= cfg_data[5:0];
                REG_HIGH_FONT_MASK: cfg_reg.high_font_mask <= cfg_data;
                REG_CURSOR_COLUMN:  cfg_reg.cursor_column  <= cfg_data[7:0];
                REG_CURSOR_ROW:     cfg_reg.cursor_row     <= cfg_data[7:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    tmpr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .address   (address),
        .value     (value),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    tmpr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    tmpr_back #(
        .CELL_DEPTH     (CELL_DEPTH),
        .GLYPH_COUNT    (GLYPH_COUNT),
        .GLYPH_ROWS_MAX (GLYPH_ROWS_MAX)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_item      (head_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .pixel_valid (pixel_valid),
        .frame_end   (frame_end)
    );

endmodule

// File: tb/tb_text_mode_pixel_renderer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_mode_pixel_renderer_core
// Self-checking bench for the text mode pixel renderer.
// Fills cell and font stores, renders pixels under many screen geometries,
// and compares every result with an in-bench raster/palette predictor or,
// for marked table rows, a typed expected pixel. Entries are written before
// any render can read them. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_text_mode_pixel_renderer_core;
    import tmpr_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       pixel_valid;
        logic       frame_end;
    } pixel_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] address;
        logic [15:0] value;
        logic        typed_in;
        pixel_t      want;
    } stim_row_t;

    localparam pixel_t NO_PIXEL  = '0;
    localparam pixel_t WHITE     = '{8'd255, 8'd255, 8'd255, 1'b1, 1'b0};
    localparam pixel_t DIM_BLUE  = '{8'd0, 8'd0, 8'd192, 1'b1, 1'b0};
    localparam pixel_t BLACK     = '{8'd0, 8'd0, 8'd0, 1'b1, 1'b0};

    localparam logic [0:15][7:0] PAL_RED = {
        8'd0, 8'd0, 8'd0, 8'd0, 8'd192, 8'd192, 8'd192, 8'd192,
        8'd64, 8'd64, 8'd64, 8'd64, 8'd255, 8'd255, 8'd255, 8'd255};
    localparam logic [0:15][7:0] PAL_GREEN = {
        8'd0, 8'd0, 8'd192, 8'd192, 8'd0, 8'd0, 8'd192, 8'd192,
        8'd64, 8'd64, 8'd255, 8'd255, 8'd64, 8'd64, 8'd255, 8'd255};
    localparam logic [0:15][7:0] PAL_BLUE = {
        8'd0, 8'd192, 8'd0, 8'd192, 8'd0, 8'd192, 8'd0, 8'd192,
        8'd64, 8'd255, 8'd64, 8'd255, 8'd64, 8'd255, 8'd64, 8'd255};

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             operation = '0;
    logic [15:0]            address = '0;
    logic [15:0]            value = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
    logic                   pixel_valid;
    logic                   frame_end;

    // predictor state
    cfg_t        settings = '{columns: COLUMNS_RST, lines: LINES_RST,
                              glyph_width: GLYPH_WIDTH_RST,
                              glyph_height: GLYPH_HEIGHT_RST,
                              high_font_mask: 16'd0, cursor_column: 8'd0,
                              cursor_row: 8'd0};
    logic [15:0] cell_words [CELL_DEPTH_DEF];
    logic [7:0]  font_bytes [FONT_DEPTH];
    bit          cell_written [CELL_DEPTH_DEF];
    bit          font_written [FONT_DEPTH];
    int          pix_col = 0;
    int          cell_col = 0;
    int          pix_row = 0;
    int          cell_row = 0;

    pixel_t      pixel_queue [$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;

    stim_row_t stim_table [23] = '{
        '{OP_WRITE_CELL, 16'h0000, 16'h1F41, 1'b1, NO_PIXEL},
        '{OP_WRITE_FONT, 16'h0820, 16'h0080, 1'b1, NO_PIXEL},
        '{OP_RENDER,     16'h0000, 16'h0000, 1'b1, WHITE},
        '{OP_RENDER,     16'hFFFF, 16'hFFFF, 1'b1, DIM_BLUE},
        '{OP_WRITE_CELL, 16'hFFFF, 16'hFFFF, 1'b1, NO_PIXEL},
        '{OP_WRITE_FONT, 16'hFFFF, 16'hFFFF, 1'b1, NO_PIXEL},
        '{OP_IGNORE,     16'hFFFF, 16'hFFFF, 1'b1, NO_PIXEL},
        '{OP_IGNORE,     16'h0000, 16'h0000, 1'b1, NO_PIXEL},
        '{OP_WRITE_CELL, 16'h2000, 16'h0000, 1'b1, NO_PIXEL},
        '{OP_WRITE_FONT, 16'h0000, 16'h00FF, 1'b1, NO_PIXEL},
        '{OP_RENDER,     16'h5555, 16'hAAAA, 1'b1, BLACK},
        '{OP_WRITE_CELL, 16'h0001, 16'hC7FF, 1'b0, NO_PIXEL},
        '{OP_WRITE_FONT, 16'h1FE0, 16'h00AA, 1'b0, NO_PIXEL},
        '{OP_RENDER,     16'h1234, 16'h8001, 1'b0, NO_PIXEL},
        '{OP_RENDER,     16'h0F0F, 16'hF0F0, 1'b0, NO_PIXEL},
        '{OP_RENDER,     16'h0000, 16'hFFFF, 1'b0, NO_PIXEL},
        '{OP_RENDER,     16'hFFFF, 16'h0000, 1'b0, NO_PIXEL},
        '{OP_RENDER,     16'h8000, 16'h0001, 1'b0, NO_PIXEL},
        '{OP_RENDER,     16'h0001, 16'h8000, 1'b0, NO_PIXEL},
        '{OP_RENDER,     16'h3C3C, 16'hC3C3, 1'b0, NO_PIXEL},
        '{OP_RENDER,     16'h00FF, 16'hFF00, 1'b0, NO_PIXEL},
        '{OP_RENDER,     16'hAAAA, 16'h5555, 1'b0, NO_PIXEL},
        '{OP_RENDER,     16'h7FFF, 16'h7FFF, 1'b0, NO_PIXEL}
    };

    text_mode_pixel_renderer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .address     (address),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .pixel_valid (pixel_valid),
        .frame_end   (frame_end)
    );

    always
    begin
        #5 clk = ~clk;
    end

    function automatic int span_cells(input logic [7:0] v);
        return (v == 8'd0) ? 1 : int'(v);
    endfunction

    function automatic int glyph_span(input logic [5:0] v);
        int r;
        if (v == 6'd0)
        begin
            r = 1;
        end
        else if (v > 6'd32)
        begin
            r = 32;
        end
        else
        begin
            r = int'(v);
        end
        return r;
    endfunction

    function automatic int cell_index();
        return (cell_row * span_cells(settings.columns) + cell_col) % CELL_DEPTH_DEF;
    endfunction

    function automatic int font_address(input logic [15:0] word);
        int glyph;
        int row_len;
        glyph = int'(word[7:0]);
        if ((word & settings.high_font_mask) != 16'd0)
        begin
            glyph = glyph + 256;
        end
        glyph = glyph % GLYPH_COUNT_DEF;
        row_len = (glyph_span(settings.glyph_width) + 7) / 8;
        return (glyph * row_len * GLYPH_ROWS_MAX_DEF + row_len * pix_row + (pix_col >> 3))
               & (FONT_DEPTH - 1);
    endfunction

    // one accepted item: update stores and raster counters, return the pixel
    function automatic pixel_t screen_step(input op_t op, input logic [15:0] addr,
                                           input logic [15:0] data);
        pixel_t      px;
        logic [15:0] word;
        logic [15:0] lower;
        logic [3:0]  color;
        bit          lit;
        bit          last_col;
        int          fa;
        px = NO_PIXEL;
        case (op)
            OP_WRITE_CELL:
            begin
                cell_words[addr % CELL_DEPTH_DEF] = data;
                cell_written[addr % CELL_DEPTH_DEF] = 1'b1;
            end
            OP_WRITE_FONT:
            begin
                font_bytes[addr] = data[7:0];
                font_written[addr] = 1'b1;
            end
            OP_RENDER:
            begin
                word = cell_words[cell_index()];
                fa = font_address(word);
                lit = font_bytes[fa][7 - (pix_col & 7)];
                if (cell_row == settings.cursor_row && cell_col == settings.cursor_column
                    && pix_row + 2 >= glyph_span(settings.glyph_height))
                begin
                    lit = 1'b1;
                end
                // squeeze the high font bit out of the attribute
                lower = settings.high_font_mask - 16'd1;
                if (lower != 16'd0)
                begin
                    word = (word & lower) | ((word >> 1) & ~lower);
                end
                color = lit ? word[11:8] : word[15:12];
                px.red = PAL_RED[color];
                px.green = PAL_GREEN[color];
                px.blue = PAL_BLUE[color];
                px.pixel_valid = 1'b1;
                last_col = 1'b0;
                if (pix_col + 1 >= glyph_span(settings.glyph_width))
                begin
                    pix_col = 0;
                    if (cell_col + 1 >= span_cells(settings.columns))
                    begin
                        cell_col = 0;
                        last_col = 1'b1;
                    end
                    else
                    begin
                        cell_col++;
                    end
                end
                else
                begin
                    pix_col++;
                end
                if (last_col)
                begin
                    if (pix_row + 1 >= glyph_span(settings.glyph_height))
                    begin
                        pix_row = 0;
                        if (cell_row + 1 >= span_cells(settings.lines))
                        begin
                            cell_row = 0;
                            px.frame_end = 1'b1;
                        end
                        else
                        begin
                            cell_row++;
                        end
                    end
                    else
                    begin
                        pix_row++;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return px;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic push_item(input op_t op, input logic [15:0] addr, input logic [15:0] data,
                             input logic typed_in, input pixel_t want);
        int     gap;
        pixel_t predicted;
        if ($urandom_range(0, 39) == 0)
        begin
            tx_steady = !tx_steady;
        end
        gap = tx_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        address   <= addr;
        value     <= data;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predicted = screen_step(op, addr, data);
        pixel_queue.push_back(typed_in ? want : predicted);
    endtask

    // write whatever the next pixel reads if it was never written, then render
    task automatic render_item(input logic [15:0] addr, input logic [15:0] data,
                               input logic typed_in, input pixel_t want);
        int idx;
        int fa;
        idx = cell_index();
        if (!cell_written[idx])
        begin
            push_item(OP_WRITE_CELL, 16'(idx + CELL_DEPTH_DEF * $urandom_range(0, 7)),
                      16'($urandom_range(0, 16'hFFFF)), 1'b0, NO_PIXEL);
        end
        fa = font_address(cell_words[idx]);
        if (!font_written[fa])
        begin
            push_item(OP_WRITE_FONT, 16'(fa), 16'($urandom_range(0, 16'hFFFF)),
                      1'b0, NO_PIXEL);
        end
        push_item(OP_RENDER, addr, data, typed_in, want);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic apply_settings(input cfg_t s);
        in_valid <= 1'b0;
        while (pixel_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        write_reg(REG_COLUMNS, 16'(s.columns));
        write_reg(REG_LINES, 16'(s.lines));
        write_reg(REG_GLYPH_WIDTH, 16'(s.glyph_width));
        write_reg(REG_GLYPH_HEIGHT, 16'(s.glyph_height));
        write_reg(REG_HIGH_FONT_MASK, s.high_font_mask);
        write_reg(REG_CURSOR_COLUMN, 16'(s.cursor_column));
        write_reg(REG_CURSOR_ROW, 16'(s.cursor_row));
        cfg_wr_en <= 1'b0;
        settings = s;
    endtask

    task automatic run_phase(input cfg_t s, input int count);
        int pick;
        apply_settings(s);
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                render_item(16'($urandom_range(0, 16'hFFFF)),
                            16'($urandom_range(0, 16'hFFFF)), 1'b0, NO_PIXEL);
            end
            else if (pick < 84)
            begin
                push_item(OP_WRITE_CELL, 16'($urandom_range(0, 16'hFFFF)),
                          16'($urandom_range(0, 16'hFFFF)), 1'b0, NO_PIXEL);
            end
            else if (pick < 97)
            begin
                push_item(OP_WRITE_FONT, 16'($urandom_range(0, 16'hFFFF)),
                          16'($urandom_range(0, 16'hFFFF)), 1'b0, NO_PIXEL);
            end
            else
            begin
                push_item(OP_IGNORE, 16'($urandom_range(0, 16'hFFFF)),
                          16'($urandom_range(0, 16'hFFFF)), 1'b0, NO_PIXEL);
            end
        end
    endtask

    // mostly small screens so frames complete, with the odd extreme value
    function automatic cfg_t random_settings();
        cfg_t s;
        case ($urandom_range(0, 9))
            0:       s.columns = 8'd0;
            1:       s.columns = 8'd255;
            default: s.columns = 8'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 9))
            0:       s.lines = 8'd0;
            1:       s.lines = 8'd255;
            default: s.lines = 8'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 9))
            0:       s.glyph_width = 6'd0;
            1:       s.glyph_width = 6'd63;
            2:       s.glyph_width = 6'd32;
            default: s.glyph_width = 6'($urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 9))
            0:       s.glyph_height = 6'd0;
            1:       s.glyph_height = 6'($urandom_range(33, 63));
            2:       s.glyph_height = 6'd2;
            default: s.glyph_height = 6'($urandom_range(1, 10));
        endcase
        case ($urandom_range(0, 5))
            0:       s.high_font_mask = 16'd0;
            1:       s.high_font_mask = 16'($urandom_range(0, 16'hFFFF));
            default: s.high_font_mask = 16'd1 << $urandom_range(0, 15);
        endcase
        s.cursor_column = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 3));
        s.cursor_row = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 3));
        return s;
    endfunction

    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : receiver
        int     hold;
        pixel_t got;
        pixel_t want;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                rx_steady = !rx_steady;
            end
            hold = rx_steady ? 0 : $urandom_range(0, 10);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            got = '{red, green, blue, pixel_valid, frame_end};
            if (pixel_queue.size() == 0)
            begin
                report_mismatch($sformatf("result %h with nothing expected", got));
            end
            else
            begin
                want = pixel_queue.pop_front();
                if (got.red !== want.red)
                begin
                    report_mismatch($sformatf("red %0d, want %0d", got.red, want.red));
                end
                if (got.green !== want.green)
                begin
                    report_mismatch($sformatf("green %0d, want %0d", got.green, want.green));
                end
                if (got.blue !== want.blue)
                begin
                    report_mismatch($sformatf("blue %0d, want %0d", got.blue, want.blue));
                end
                if (got.pixel_valid !== want.pixel_valid)
                begin
                    report_mismatch($sformatf("pixel_valid %b, want %b",
                                              got.pixel_valid, want.pixel_valid));
                end
                if (got.frame_end !== want.frame_end)
                begin
                    report_mismatch($sformatf("frame_end %b, want %b",
                                              got.frame_end, want.frame_end));
                end
            end
        end
    end

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            if (stim_table[i].op == OP_RENDER)
            begin
                render_item(stim_table[i].address, stim_table[i].value,
                            stim_table[i].typed_in, stim_table[i].want);
            end
            else
            begin
                push_item(stim_table[i].op, stim_table[i].address, stim_table[i].value,
                          stim_table[i].typed_in, stim_table[i].want);
            end
        end

        // one-column screen walks the row counter down fast; the next phase
        // then widens it so row * columns passes the cell store depth
        run_phase('{columns: 8'd1, lines: 8'd255, glyph_width: 6'd1, glyph_height: 6'd1,
                    high_font_mask: 16'h8000, cursor_column: 8'd0, cursor_row: 8'd5}, 80);
        run_phase('{columns: 8'd255, lines: 8'd5, glyph_width: 6'd1, glyph_height: 6'd1,
                    high_font_mask: 16'h0100, cursor_column: 8'd200, cursor_row: 8'd40}, 120);
        // counters now sit past the shrunken geometry
        run_phase('{columns: 8'd2, lines: 8'd2, glyph_width: 6'd0, glyph_height: 6'd2,
                    high_font_mask: 16'h0000, cursor_column: 8'd1, cursor_row: 8'd1}, 120);
        run_phase('{columns: 8'd255, lines: 8'd255, glyph_width: 6'd63, glyph_height: 6'd63,
                    high_font_mask: 16'hFFFF, cursor_column: 8'd255, cursor_row: 8'd255},
                  100);
        run_phase('{columns: 8'd0, lines: 8'd0, glyph_width: 6'd32, glyph_height: 6'd32,
                    high_font_mask: 16'h0001, cursor_column: 8'd0, cursor_row: 8'd0}, 120);
        repeat (4)
        begin
            run_phase(random_settings(), 110);
        end

        in_valid <= 1'b0;
        while (pixel_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
